>>> hdl/cwb_pkg.sv
package cwb_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT     = 1024;
  localparam int MAX_HEIGHT_DEFAULT    = 1024;
  localparam int FRACTION_BITS_DEFAULT = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 29;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_FOCAL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_ANGLE    = 3'd4;

  localparam logic [10:0] SOURCE_WIDTH_RESET  = 11'd1024;
  localparam logic [10:0] SOURCE_HEIGHT_RESET = 11'd1024;
  localparam logic [23:0] FOCAL_RESET         = 24'd262144;
  localparam logic [28:0] INVERSE_FOCAL_RESET = 29'd262144;
  localparam logic [20:0] HALF_ANGLE_RESET    = 21'd486169;

  // Frame sizes up to 4096 need 13 bits.
  localparam int DIM_W = 13;

  // Angle arithmetic.
  localparam int ANGLE_W = 39;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q28 = 39'd421657428;
  localparam int OFFSET_LIMIT_BITS = 13;

  // Rotation unit.
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd1768195363;

  // Result classes.
  localparam logic [1:0] KIND_INTERIOR = 2'd0;
  localparam logic [1:0] KIND_EDGE     = 2'd1;
  localparam logic [1:0] KIND_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [9:0] column;
    logic [9:0] row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] hit_kind;
  } out_item_t;

  // Arc tangent of 2^-step with 30 fractional bits.
  function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int step);
    logic signed [CORDIC_W-1:0] a;
    case (step)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048576;
      11:      a = 34'sd524288;
      12:      a = 34'sd262144;
      13:      a = 34'sd131072;
      14:      a = 34'sd65536;
      15:      a = 34'sd32768;
      16:      a = 34'sd16384;
      17:      a = 34'sd8192;
      18:      a = 34'sd4096;
      19:      a = 34'sd2048;
      20:      a = 34'sd1024;
      21:      a = 34'sd512;
      22:      a = 34'sd256;
      23:      a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/cylindrical_warp_bilinear_top.sv
// Queries give a result on the output; loads give no result.
// Throughput: one item per cycle unless the output stalls, loads and queries freely mixed;
// the depth is set by the 24-stage rotation unit and the two bit-per-stage dividers of
// 13 + FRACTION_BITS stages.
// Reset (rst, synchronous): clears the pipeline valid bits and the output valid, and returns
// the configuration registers to their defaults; the source frame has no clearing pass.
module cylindrical_warp_bilinear_top #(
  parameter int MAX_WIDTH     = cwb_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT    = cwb_pkg::MAX_HEIGHT_DEFAULT,
  parameter int FRACTION_BITS = cwb_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cwb_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cwb_pkg::out_item_t               out_data,
  input  logic                             cfg_write,
  input  logic [cwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Widths that follow from the fraction bits. Offsets are bounded by the range check
  // ahead of the dividers, so both quotients fit in QW bits.
  localparam int FB    = FRACTION_BITS;
  localparam int UP    = (FB > 8) ? FB - 8 : 0;
  localparam int DOWN  = (FB < 8) ? 8 - FB : 0;
  localparam int QW    = FB + cwb_pkg::OFFSET_LIMIT_BITS;
  localparam int DS_W  = FB + 13;
  localparam int AD_W  = FB + 12;
  localparam int N_W   = 55;
  localparam int NX_W  = N_W + UP;
  localparam int DX_W  = 31 + DOWN;
  localparam int M_W   = AD_W + 31;
  localparam int MC_W  = M_W + 1;
  localparam int SX_W  = FB + 15;
  localparam int WT_W  = 2 * FB + 1;
  localparam int PR_W  = WT_W + 8;
  localparam int ACC_W = PR_W + 2;
  localparam int DW    = cwb_pkg::DIM_W;
  localparam int CW    = cwb_pkg::CORDIC_W;
  localparam int CS    = cwb_pkg::CORDIC_STEPS;
  localparam int AW_A  = cwb_pkg::ANGLE_W;

  // The frame is split into four banks by the parity of column and row, so the four
  // neighbours of a bilinear sample always sit in four different banks.
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Positions of the stages in the sideband line.
  localparam int IX_P2 = 1;
  localparam int IX_P3 = 2 + CS;
  localparam int IX_P4 = 3 + CS;
  localparam int IX_P5 = 4 + CS + QW;
  localparam int IX_P6 = 5 + CS + QW;
  localparam int IX_P8 = 7 + CS + QW;
  localparam int NST   = 8 + CS + QW;

  // What every item carries down the pipeline beside its arithmetic.
  typedef struct packed {
    logic        valid;
    logic        query;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [23:0] pixel;
    logic        d_neg;
    logic        minus;
    logic        steep;
    logic        ok;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Users write only while the block is idle; it is not enforced.
  // ---------------------------------------------------------------------------
  logic [10:0] source_width, source_height;
  logic [23:0] focal_q8;
  logic [28:0] inverse_focal_q28;
  logic [20:0] half_angle_q20;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width      <= cwb_pkg::SOURCE_WIDTH_RESET;
      source_height     <= cwb_pkg::SOURCE_HEIGHT_RESET;
      focal_q8          <= cwb_pkg::FOCAL_RESET;
      inverse_focal_q28 <= cwb_pkg::INVERSE_FOCAL_RESET;
      half_angle_q20    <= cwb_pkg::HALF_ANGLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cwb_pkg::REG_SOURCE_WIDTH:  source_width      <= cfg_data[10:0];
        cwb_pkg::REG_SOURCE_HEIGHT: source_height     <= cfg_data[10:0];
        cwb_pkg::REG_FOCAL:         focal_q8          <= cfg_data[23:0];
        cwb_pkg::REG_INVERSE_FOCAL: inverse_focal_q28 <= cfg_data[28:0];
        cwb_pkg::REG_HALF_ANGLE:    half_angle_q20    <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // Frame size, clamped to the storage, and the values derived from it. These must
  // stay static while items are in flight, up to the user; every stage reads them directly.
  logic [DW-1:0]          w_eff, h_eff;
  logic signed [SX_W-1:0] half_w, half_h, lim_x, lim_y;
  logic [DS_W-1:0]        half_h_d;

  assign w_eff = (DW'(source_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(source_width);
  assign h_eff = (DW'(source_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(source_height);
  assign half_w   = $signed(SX_W'(w_eff)) <<< (FB - 1);
  assign half_h   = $signed(SX_W'(h_eff)) <<< (FB - 1);
  assign half_h_d = DS_W'(h_eff) << (FB - 1);
  // A zero-sized frame gives a negative limit, which no coordinate can meet.
  assign lim_x = ($signed(SX_W'(w_eff)) - SX_W'(1)) <<< FB;
  assign lim_y = ($signed(SX_W'(h_eff)) - SX_W'(1)) <<< FB;

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it freezes only while the
  // output register holds a result that the far side is stalling.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  side_t sd [NST];
  side_t sd_p2, sd_p4;
  logic  ok_c;

  // Stage 1: angle of the output column and the row offset from the frame centre.
  logic [AW_A-1:0]        ang1;
  logic [AD_W-1:0]        ad1;
  logic signed [DS_W-1:0] d_in;
  logic [AD_W-1:0]        ad_in;

  assign d_in  = $signed(DS_W'(in_data.row) << FB) - $signed(half_h_d);
  assign ad_in = d_in[DS_W-1] ? AD_W'(-d_in) : AD_W'(d_in);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang1 <= AW_A'(in_data.column) * AW_A'(inverse_focal_q28);
      ad1  <= ad_in;
    end
  end

  // Stage 2: distance of the angle from the frame's half angle.
  logic [AW_A-1:0]      half_ang, diff_c;
  logic                 minus_c, steep_c;
  logic signed [CW-1:0] theta2;
  logic [AD_W-1:0]      ad2;

  assign half_ang = AW_A'(half_angle_q20) << 8;
  assign minus_c  = ang1 <= half_ang;
  assign diff_c   = minus_c ? half_ang - ang1 : ang1 - half_ang;
  assign steep_c  = diff_c >= cwb_pkg::HALF_PI_Q28;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Only meaningful when the angle is below a right angle, where it fits.
      theta2 <= $signed({diff_c[CW-3:0], 2'b00});
      ad2    <= ad1;
    end
  end

  // Sideband line; the minus and steep flags join at stage 2 and the range check at
  // stage 4.
  always_comb begin
    sd_p2       = sd[IX_P2-1];
    sd_p2.minus = minus_c;
    sd_p2.steep = steep_c;
    sd_p4       = sd[IX_P4-1];
    sd_p4.ok    = ok_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        sd[k] <= '0;
      end
    end else if (adv) begin
      sd[0].valid  <= in_valid;
      sd[0].query  <= in_data.mode;
      sd[0].column <= in_data.column;
      sd[0].row    <= in_data.row;
      sd[0].pixel  <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      sd[0].d_neg  <= d_in[DS_W-1];
      sd[0].minus  <= 1'b0;
      sd[0].steep  <= 1'b0;
      sd[0].ok     <= 1'b0;
      for (int k = 1; k < NST; k++) begin
        if (k == IX_P2) begin
          sd[k] <= sd_p2;
        end else if (k == IX_P4) begin
          sd[k] <= sd_p4;
        end else begin
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  // Rotation unit: K*cos and K*sin of the angle difference.
  logic signed [CW-1:0] kc, ks;

  cwb_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .theta (theta2),
    .cos_k (kc),
    .sin_k (ks)
  );

  logic [AD_W-1:0] ad_d [CS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ad_d[0] <= ad2;
      for (int k = 1; k < CS; k++) begin
        ad_d[k] <= ad_d[k-1];
      end
    end
  end

  // Stage 3: numerators of both offsets. The sine is clamped at zero.
  logic [N_W-1:0] n3;
  logic [M_W-1:0] m3;
  logic [30:0]    kc3;
  logic           kc_pos3;
  logic [30:0]    ysin;

  assign ysin = (!ks[CW-1] && ks != '0) ? ks[30:0] : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      n3      <= N_W'(ysin) * N_W'(focal_q8);
      m3      <= M_W'(ad_d[CS-1]) * M_W'(cwb_pkg::CORDIC_GAIN_Q30);
      kc3     <= kc[30:0];
      kc_pos3 <= !kc[CW-1] && kc != '0;
    end
  end

  // Stage 4: both offsets must stay below the limit, which also bounds the quotients.
  logic [NX_W-1:0] num_x4;
  logic [DX_W-1:0] den_x4;
  logic [M_W-1:0]  num_y4;
  logic [30:0]     den_y4;

  assign ok_c = kc_pos3 &&
                (n3 < (N_W'(kc3) << (8 + cwb_pkg::OFFSET_LIMIT_BITS))) &&
                (MC_W'(m3) < (MC_W'(kc3) << (FB + cwb_pkg::OFFSET_LIMIT_BITS)));

  always_ff @(posedge clk) begin
    if (adv) begin
      num_x4 <= NX_W'(n3) << UP;
      den_x4 <= DX_W'(kc3) << DOWN;
      num_y4 <= m3;
      den_y4 <= kc3;
    end
  end

  // Offsets: f*tan across, row offset over cosine down.
  logic [QW-1:0] off_x, off_y;

  cwb_divider #(.NUM_W(NX_W), .DEN_W(DX_W), .QUO_W(QW)) u_div_x (
    .clk (clk),
    .en  (adv),
    .num (num_x4),
    .den (den_x4),
    .quo (off_x)
  );

  cwb_divider #(.NUM_W(M_W), .DEN_W(31), .QUO_W(QW)) u_div_y (
    .clk (clk),
    .en  (adv),
    .num (num_y4),
    .den (den_y4),
    .quo (off_y)
  );

  // Stage 5: source coordinates and their class.
  logic signed [SX_W-1:0] sx_c, sy_c;
  logic                   live_c, in_x_c, in_y_c, on_x_c, on_y_c;
  logic                   interior5, edge5;
  logic [XW-1:0]          cx5;
  logic [YW-1:0]          cy5;
  logic [FB-1:0]          u5, v5;

  assign sx_c = sd[IX_P5-1].minus ? half_w - $signed(SX_W'(off_x))
                                  : half_w + $signed(SX_W'(off_x));
  assign sy_c = sd[IX_P5-1].d_neg ? half_h - $signed(SX_W'(off_y))
                                  : half_h + $signed(SX_W'(off_y));
  assign live_c = sd[IX_P5-1].query && !sd[IX_P5-1].steep && sd[IX_P5-1].ok;
  assign in_x_c = !sx_c[SX_W-1] && sx_c < lim_x;
  assign in_y_c = !sy_c[SX_W-1] && sy_c < lim_y;
  assign on_x_c = !sx_c[SX_W-1] && sx_c <= lim_x;
  assign on_y_c = !sy_c[SX_W-1] && sy_c <= lim_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      interior5 <= live_c && in_x_c && in_y_c;
      // The edge copy needs both coordinates in range and one exactly on the far edge.
      edge5     <= live_c && !(in_x_c && in_y_c) && on_x_c && on_y_c &&
                   (sx_c == lim_x || sy_c == lim_y);
      cx5       <= sx_c[XW+FB-1:FB];
      cy5       <= sy_c[YW+FB-1:FB];
      u5        <= sx_c[FB-1:0];
      v5        <= sy_c[FB-1:0];
    end
  end

  // Stage 6: bank addresses for the four neighbours or the load, and the weights.
  // An edge copy takes the full weight on the top-left neighbour.
  logic [AW-1:0]   addr6 [4];
  logic [3:0]      we6;
  logic [23:0]     wdata6;
  logic [WT_W-1:0] w6 [4];
  logic [3:0]      use6;
  logic [1:0]      kind6;
  logic            px6, py6;

  logic [AW-1:0]   addr_c [4];
  logic [3:0]      we_c;
  logic [WT_W-1:0] w_c [4];
  logic [3:0]      use_c;
  logic [1:0]      kind_c;
  logic [FB:0]     one_c, ou_c, ov_c;
  logic            load_c, range_c;
  logic [XW:0]     xq_c;
  logic [YW:0]     yq_c;

  always_comb begin
    one_c   = (FB + 1)'(1) << FB;
    ou_c    = one_c - (FB + 1)'(u5);
    ov_c    = one_c - (FB + 1)'(v5);
    load_c  = sd[IX_P6-1].valid && !sd[IX_P6-1].query;
    range_c = (DW'(sd[IX_P6-1].column) < DW'(MAX_WIDTH)) &&
              (DW'(sd[IX_P6-1].row) < DW'(MAX_HEIGHT));
    for (int b = 0; b < 4; b++) begin
      xq_c = (XW + 1)'(cx5) + (XW + 1)'(b[0] ^ cx5[0]);
      yq_c = (YW + 1)'(cy5) + (YW + 1)'(b[1] ^ cy5[0]);
      if (sd[IX_P6-1].query) begin
        addr_c[b] = AW'(yq_c[YW:1] * BANK_COLS) + AW'(xq_c[XW:1]);
      end else begin
        addr_c[b] = AW'(sd[IX_P6-1].row[9:1] * BANK_COLS) + AW'(sd[IX_P6-1].column[9:1]);
      end
      we_c[b] = load_c && range_c &&
                (sd[IX_P6-1].row[0] == b[1]) && (sd[IX_P6-1].column[0] == b[0]);
    end
    if (interior5) begin
      kind_c = cwb_pkg::KIND_INTERIOR;
      use_c  = 4'b1111;
      w_c[0] = WT_W'(ou_c) * WT_W'(ov_c);
      w_c[1] = WT_W'(u5) * WT_W'(ov_c);
      w_c[2] = WT_W'(ou_c) * WT_W'(v5);
      w_c[3] = WT_W'(u5) * WT_W'(v5);
    end else if (edge5) begin
      kind_c = cwb_pkg::KIND_EDGE;
      use_c  = 4'b0001;
      w_c[0] = WT_W'(1) << (2 * FB);
      w_c[1] = '0;
      w_c[2] = '0;
      w_c[3] = '0;
    end else begin
      kind_c = cwb_pkg::KIND_OUTSIDE;
      use_c  = 4'b0000;
      for (int k = 0; k < 4; k++) begin
        w_c[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int b = 0; b < 4; b++) begin
        addr6[b] <= addr_c[b];
        w6[b]    <= w_c[b];
      end
      we6    <= we_c;
      wdata6 <= sd[IX_P6-1].pixel;
      use6   <= use_c;
      kind6  <= kind_c;
      px6    <= cx5[0];
      py6    <= cy5[0];
    end
  end

  // Stage 7: frame banks. Loads write at the same stage where queries read, so every
  // query sees exactly the loads that were transferred before it.
  logic [23:0] rd7 [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0] mem [BANK_DEPTH];
    logic [23:0] rdq;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (we6[b]) begin
          mem[addr6[b]] <= wdata6;
        end
        rdq <= mem[addr6[b]];
      end
    end
    assign rd7[b] = rdq;
  end

  logic [WT_W-1:0] w7 [4];
  logic [3:0]      use7;
  logic [1:0]      kind7;
  logic            px7, py7;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        w7[k] <= w6[k];
      end
      use7  <= use6;
      kind7 <= kind6;
      px7   <= px6;
      py7   <= py6;
    end
  end

  // Stage 8: weighted channels. Neighbour k sits in the bank whose parity differs from
  // the top-left one by k; unused neighbours count as black.
  logic [PR_W-1:0] prod8 [4][3];
  logic [1:0]      kind8;
  logic [23:0]     pix_c [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix_c[k] = use7[k] ? rd7[{py7 ^ k[1], px7 ^ k[0]}] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod8[k][c] <= PR_W'(w7[k]) * PR_W'(pix_c[k][8*c +: 8]);
        end
      end
      kind8 <= kind7;
    end
  end

  // Output register: sum, floor and hand over.
  logic [ACC_W-1:0] acc_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_c[c] = ACC_W'(prod8[0][c]) + ACC_W'(prod8[1][c]) +
                 ACC_W'(prod8[2][c]) + ACC_W'(prod8[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sd[IX_P8].valid && sd[IX_P8].query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.red_out   <= acc_c[2][2*FB +: 8];
      out_data.green_out <= acc_c[1][2*FB +: 8];
      out_data.blue_out  <= acc_c[0][2*FB +: 8];
      out_data.hit_kind  <= kind8;
    end
  end

`ifndef ASSERT_OFF
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hit_kind != 2'd3)
    else $error("result carries an undefined hit kind");

  a_black_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit_kind == cwb_pkg::KIND_OUTSIDE |->
      out_data.red_out == 8'd0 && out_data.green_out == 8'd0 && out_data.blue_out == 8'd0)
    else $error("outside result is not black");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    adv && sd[IX_P8].valid && !sd[IX_P8].query |=> !out_valid)
    else $error("a load produced a result");

  a_steep_outside: assert property (@(posedge clk) disable iff (rst)
    adv && sd[IX_P8].valid && sd[IX_P8].query && sd[IX_P8].steep |=>
      out_valid && out_data.hit_kind == cwb_pkg::KIND_OUTSIDE)
    else $error("steep angle did not give an outside result");
`endif

endmodule

>>> hdl/cwb_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage.
module cwb_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [cwb_pkg::CORDIC_W-1:0] theta,
  output logic signed [cwb_pkg::CORDIC_W-1:0] cos_k,
  output logic signed [cwb_pkg::CORDIC_W-1:0] sin_k
);

  localparam int N = cwb_pkg::CORDIC_STEPS;
  localparam int W = cwb_pkg::CORDIC_W;
  localparam logic signed [W-1:0] X_START = W'(1073741824);

  logic signed [W-1:0] xs [N];
  logic signed [W-1:0] ys [N];
  logic signed [W-1:0] zs [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] xp, yp, zp, dx, dy;
    if (i == 0) begin : g_first
      assign xp = X_START;
      assign yp = '0;
      assign zp = theta;
    end else begin : g_next
      assign xp = xs[i-1];
      assign yp = ys[i-1];
      assign zp = zs[i-1];
    end
    assign dx = yp >>> i;
    assign dy = xp >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[W-1]) begin
          xs[i] <= xp - dx;
          ys[i] <= yp + dy;
          zs[i] <= zp - cwb_pkg::cordic_atan(i);
        end else begin
          xs[i] <= xp + dx;
          ys[i] <= yp - dy;
          zs[i] <= zp + cwb_pkg::cordic_atan(i);
        end
      end
    end
  end

  assign cos_k = xs[N-1];
  assign sin_k = ys[N-1];

endmodule

>>> hdl/cwb_divider.sv
// Restoring divider, one quotient bit per register stage, most significant first.
// The quotient must fit in QUO_W bits.
module cwb_divider #(
  parameter int NUM_W = 55,
  parameter int DEN_W = 31,
  parameter int QUO_W = 21
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int BIT = QUO_W - 1 - j;
    logic [NUM_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p;
    logic [CMP_W-1:0] trial, rem_w;
    if (j == 0) begin : g_first
      assign rem_p = num;
      assign den_p = den;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end
    assign trial = CMP_W'(den_p) << BIT;
    assign rem_w = CMP_W'(rem_p);
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= den_p;
        if (rem_w >= trial) begin
          rem_q[j] <= NUM_W'(rem_w - trial);
          quo_q[j] <= quo_p | (QUO_W'(1) << BIT);
        end else begin
          rem_q[j] <= rem_p;
          quo_q[j] <= quo_p;
        end
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule
